// ----- src/quaternion_to_euler_angles_core_defines.svh -----
// Assertion macros shared by the quaternion to Euler angle block.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_DEFINES_SVH

// Check that holds outside reset.
`define Q2E_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also covers the reset cycles.
`define Q2E_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/q2e_pkg.sv -----
// Shared types and constants for the quaternion to Euler angle block.
// No dependencies.
package q2e_pkg;

  localparam int DW      = 64;   // datapath width for Q30 values
  localparam int AW      = 34;   // Q30 angle accumulator width
  localparam int TAB_LEN = 31;
  localparam int SQ_W    = 62;   // square root working width
  localparam int ROOT_STEPS = 31;

  typedef logic signed [DW-1:0] dat_t;
  typedef logic signed [AW-1:0] ang_t;
  typedef logic signed [15:0]   q13_t;

  localparam q13_t HALF_PI_Q13 = 16'sd12868;

  // atan(2^-i) in Q30
  localparam ang_t ATAN_TAB [TAB_LEN] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159, 34'sd67021687,
    34'sd33543516, 34'sd16775851, 34'sd8388437, 34'sd4194283, 34'sd2097149,
    34'sd1048576, 34'sd524288, 34'sd262144, 34'sd131072, 34'sd65536, 34'sd32768,
    34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048, 34'sd1024, 34'sd512, 34'sd256,
    34'sd128, 34'sd64, 34'sd32, 34'sd16, 34'sd8, 34'sd4, 34'sd2, 34'sd1
  };

  // Per-item values carried alongside the pitch square root.
  typedef struct packed {
    dat_t sy;     // yaw sine term, Q30
    dat_t cy;     // yaw cosine term, Q30
    dat_t sr;     // roll sine term, Q30
    dat_t cr;     // roll cosine term, Q30
    dat_t s;      // pitch sine, Q30
    logic clamp;  // pitch argument reached magnitude one
    logic neg;    // pitch argument negative
  } side_t;

endpackage

// ----- src/q2e_front.sv -----
// Front end: quaternion products, sums and scaling to Q30, three stages.
// Depends on q2e_pkg.
module q2e_front import q2e_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [15:0] w,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  logic signed [15:0] z,
  output logic               out_valid,
  output side_t              side
);

  localparam int   SHIFT_D = 2 * FRAC_BITS - 30;
  localparam int   SHR     = (SHIFT_D > 0) ? SHIFT_D : 0;
  localparam int   SHL     = (SHIFT_D < 0) ? -SHIFT_D : 0;
  localparam dat_t ONE     = 64'sd1 <<< (2 * FRAC_BITS);

  function automatic dat_t to_q30(input dat_t v);
    return (v >>> SHR) <<< SHL;
  endfunction

  logic signed [31:0] p_wy, p_zx, p_wz, p_yx, p_yy, p_zz, p_wx, p_yz, p_xx;
  dat_t sinp, siny, cosy, sinr, cosr;
  logic va, vb;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wy <= w * y;
      p_zx <= z * x;
      p_wz <= w * z;
      p_yx <= y * x;
      p_yy <= y * y;
      p_zz <= z * z;
      p_wx <= w * x;
      p_yz <= y * z;
      p_xx <= x * x;

      sinp <= (DW'(p_wy) - DW'(p_zx)) <<< 1;
      siny <= (DW'(p_wz) + DW'(p_yx)) <<< 1;
      cosy <= ONE - ((DW'(p_yy) + DW'(p_zz)) <<< 1);
      sinr <= (DW'(p_wx) + DW'(p_yz)) <<< 1;
      cosr <= ONE - ((DW'(p_xx) + DW'(p_yy)) <<< 1);

      side.clamp <= (sinp >= ONE) || (sinp <= -ONE);
      side.neg   <= sinp < 0;
      side.s     <= to_q30(sinp);
      side.sy    <= to_q30(siny);
      side.cy    <= to_q30(cosy);
      side.sr    <= to_q30(sinr);
      side.cr    <= to_q30(cosr);
    end
  end

endmodule

// ----- src/q2e_isqrt.sv -----
// Pipelined integer square root for the pitch cosine, one result bit a stage.
// Depends on q2e_pkg.
module q2e_isqrt import q2e_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  side_t in_side,
  output logic  out_valid,
  output side_t out_side,
  output dat_t  root_out
);

  logic [30:0]     s2;
  logic [SQ_W-1:0] s2_w;
  logic [SQ_W-1:0] rem  [ROOT_STEPS+1];
  logic [SQ_W-1:0] root [ROOT_STEPS+1];
  logic            vld  [ROOT_STEPS+1];
  side_t           sd   [ROOT_STEPS+1];

  // |s| limited to one in Q30
  always_comb begin
    logic [DW-1:0] mag;
    mag = in_side.s[DW-1] ? DW'(-in_side.s) : DW'(in_side.s);
    s2  = (mag > DW'(64'd1 << 30)) ? 31'(64'd1 << 30) : mag[30:0];
  end

  assign s2_w = SQ_W'(s2);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= (SQ_W'(1) << 60) - (s2_w * s2_w);
      root[0] <= '0;
      sd[0]   <= in_side;
    end
  end

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - k));
    logic [SQ_W-1:0] trial;
    assign trial = root[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[k+1] <= sd[k];
        if (rem[k] >= trial) begin
          rem[k+1]  <= rem[k] - trial;
          root[k+1] <= (root[k] >> 1) + BIT;
        end else begin
          rem[k+1]  <= rem[k];
          root[k+1] <= root[k] >> 1;
        end
      end
    end
  end

  assign out_valid = vld[ROOT_STEPS];
  assign out_side  = sd[ROOT_STEPS];
  assign root_out  = DW'(root[ROOT_STEPS]);

endmodule

// ----- src/q2e_cordic.sv -----
// Pipelined vectoring CORDIC atan2, one iteration a stage, Q3.13 result.
// Depends on q2e_pkg.
module q2e_cordic import q2e_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  dat_t y_in,
  input  dat_t x_in,
  output logic out_valid,
  output q13_t angle
);

  dat_t xr   [STEPS+1];
  dat_t yr   [STEPS+1];
  ang_t ar   [STEPS+1];
  logic zr   [STEPS+1];
  logic vld  [STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0]    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0]    <= in_valid;
      out_valid <= vld[STEPS];
    end
  end

  // left half plane: turn by a quarter first
  always_ff @(posedge clk) begin
    if (en) begin
      zr[0] <= (x_in == 0) && (y_in == 0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          xr[0] <= y_in;
          yr[0] <= -x_in;
          ar[0] <= ATAN_TAB[0] <<< 1;
        end else begin
          xr[0] <= -y_in;
          yr[0] <= x_in;
          ar[0] <= -(ATAN_TAB[0] <<< 1);
        end
      end else begin
        xr[0] <= x_in;
        yr[0] <= y_in;
        ar[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    dat_t xs, ys;
    assign xs = xr[i] >>> i;
    assign ys = yr[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zr[i+1] <= zr[i];
        if (yr[i] > 0) begin
          xr[i+1] <= xr[i] + ys;
          yr[i+1] <= yr[i] - xs;
          ar[i+1] <= ar[i] + ATAN_TAB[i];
        end else begin
          xr[i+1] <= xr[i] - ys;
          yr[i+1] <= yr[i] + xs;
          ar[i+1] <= ar[i] - ATAN_TAB[i];
        end
      end
    end
  end

  // round half up to Q13 and saturate
  ang_t rnd;
  assign rnd = (ar[STEPS] + ang_t'(65536)) >>> 17;

  always_ff @(posedge clk) begin
    if (en) begin
      if (zr[STEPS]) begin
        angle <= '0;
      end else if (rnd > ang_t'(32767)) begin
        angle <= 16'sd32767;
      end else if (rnd < -ang_t'(32768)) begin
        angle <= -16'sd32768;
      end else begin
        angle <= rnd[15:0];
      end
    end
  end

endmodule

// ----- src/quaternion_to_euler_angles_core.sv -----
// Quaternion (Q2.14) to ZYX Euler angles (Q3.13): yaw, pitch, roll.
// Pipeline: front end, square root, then three parallel CORDIC atan2 lanes.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset (rst, synchronous) clears every stage valid bit; data registers keep junk.
// Depends on q2e_pkg, q2e_front, q2e_isqrt, q2e_cordic and the defines header.
`include "quaternion_to_euler_angles_core_defines.svh"
module quaternion_to_euler_angles_core import q2e_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               quat_valid,
  output logic               quat_ready,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               euler_valid,
  input  logic               euler_ready,
  output logic signed [15:0] yaw_angle,
  output logic signed [15:0] pitch_angle,
  output logic signed [15:0] roll_angle,
  output logic               pitch_clamped
);

  localparam int LAT_C = CORDIC_STEPS + 2;

  // Single stall signal: every stage moves when the output slot is free.
  logic  adv;
  assign adv        = !euler_valid || euler_ready;
  assign quat_ready = adv;

  logic  f_valid, r_valid;
  side_t f_side, r_side;
  dat_t  root;

  q2e_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .en(adv), .in_valid(quat_valid),
    .w(quat_w), .x(quat_x), .y(quat_y), .z(quat_z),
    .out_valid(f_valid), .side(f_side)
  );

  // Pitch cosine = sqrt(1 - s^2); yaw and roll terms ride along.
  q2e_isqrt u_isqrt (
    .clk, .rst, .en(adv), .in_valid(f_valid), .in_side(f_side),
    .out_valid(r_valid), .out_side(r_side), .root_out(root)
  );

  logic yaw_v, pitch_v, roll_v;
  q13_t yaw_a, pitch_a, roll_a;

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk, .rst, .en(adv), .in_valid(r_valid),
    .y_in(r_side.sy), .x_in(r_side.cy), .out_valid(yaw_v), .angle(yaw_a)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk, .rst, .en(adv), .in_valid(r_valid),
    .y_in(r_side.s), .x_in(root), .out_valid(pitch_v), .angle(pitch_a)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk, .rst, .en(adv), .in_valid(r_valid),
    .y_in(r_side.sr), .x_in(r_side.cr), .out_valid(roll_v), .angle(roll_a)
  );

  // Clamp flag and sign follow the item through the CORDIC stages.
  logic cl_d [LAT_C];
  logic ng_d [LAT_C];

  always_ff @(posedge clk) begin
    if (adv) begin
      cl_d[0] <= r_side.clamp;
      ng_d[0] <= r_side.neg;
      for (int i = 1; i < LAT_C; i++) begin
        cl_d[i] <= cl_d[i-1];
        ng_d[i] <= ng_d[i-1];
      end
    end
  end

  assign euler_valid   = pitch_v;
  assign yaw_angle     = yaw_a;
  assign roll_angle    = roll_a;
  assign pitch_clamped = cl_d[LAT_C-1];
  // Saturated pitch: plus or minus pi/2 with the argument's sign.
  assign pitch_angle   = !cl_d[LAT_C-1] ? pitch_a :
                         (ng_d[LAT_C-1] ? -HALF_PI_Q13 : HALF_PI_Q13);

  `Q2E_CHECK(a_lanes_aligned, (yaw_v == pitch_v) && (roll_v == pitch_v), "angle lanes out of step")
  `Q2E_CHECK_RST(a_reset_empty, rst |=> !euler_valid, "result valid right after reset")
  `Q2E_CHECK(a_clamp_value, (euler_valid && pitch_clamped) |-> ((pitch_angle == HALF_PI_Q13) || (pitch_angle == -HALF_PI_Q13)), "clamped pitch not pi/2")
  `Q2E_CHECK(a_stall_holds, (euler_valid && !euler_ready) |=> (euler_valid && $stable(yaw_angle) && $stable(pitch_angle)), "stalled result changed")

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for quaternion_to_euler_angles_core (quaternion to ZYX Euler).
// Depends on q2e_pkg and the block RTL; a local bit-exact predictor checks every result.
`timescale 1ns / 1ps

// Predicts the angles of each accepted quaternion and checks results in order.
class euler_scoreboard;
  typedef struct {
    q2e_pkg::q13_t yaw;
    q2e_pkg::q13_t pitch;
    q2e_pkg::q13_t roll;
    logic          clamped;
  } euler_t;

  localparam int STEPS = 16;
  localparam int FB    = 14;
  localparam int QF    = 30;   // angle/argument fraction bits

  euler_t angles_due[$];
  int     errors;

  function new();
    errors = 0;
  endfunction

  function int pending();
    return angles_due.size();
  endfunction

  // Product sums carry 2*FB fraction bits; bring them to Q30.
  function longint to_q30(longint v);
    int d;
    d = 2 * FB - QF;
    if (d >= 0) return v >>> d;
    return v <<< (-d);
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC atan2, Q30 angle, rounded half up to Q13 and saturated.
  function q2e_pkg::q13_t atan2_q13(longint ys, longint xs);
    longint ang, t, xv, yv, dx, dy, r;
    int n;
    ang = 0;
    xv  = xs;
    yv  = ys;
    if (xv == 0 && yv == 0) return '0;
    // left half plane: pre-rotate by a quarter turn
    if (xv < 0) begin
      if (yv >= 0) begin
        t = xv; xv = yv; yv = -t;
        ang = 2 * longint'(q2e_pkg::ATAN_TAB[0]);
      end else begin
        t = xv; xv = -yv; yv = t;
        ang = -2 * longint'(q2e_pkg::ATAN_TAB[0]);
      end
    end
    n = (STEPS > 31) ? 31 : STEPS;
    for (int i = 0; i < n; i++) begin
      dx = xv >>> i;
      dy = yv >>> i;
      if (yv > 0) begin
        xv = xv + dy; yv = yv - dx; ang = ang + longint'(q2e_pkg::ATAN_TAB[i]);
      end else begin
        xv = xv - dy; yv = yv + dx; ang = ang - longint'(q2e_pkg::ATAN_TAB[i]);
      end
    end
    r = (ang + (64'sd1 <<< 16)) >>> 17;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return q2e_pkg::q13_t'(r);
  endfunction

  function void note_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                          logic signed [15:0] qy, logic signed [15:0] qz);
    longint w, x, y, z, one, sinp, siny, cosy, sinr, cosr, s;
    longint unsigned s2, c;
    euler_t e;
    w = qw; x = qx; y = qy; z = qz;
    one  = 64'sd1 <<< (2 * FB);
    sinp = 2 * (w * y - z * x);
    siny = 2 * (w * z + y * x);
    cosy = one - 2 * (y * y + z * z);
    sinr = 2 * (w * x + y * z);
    cosr = one - 2 * (x * x + y * y);
    // gimbal lock: |sin pitch| >= 1 clamps to +-pi/2
    if (sinp >= one || sinp <= -one) begin
      e.pitch   = (sinp < 0) ? -q2e_pkg::HALF_PI_Q13 : q2e_pkg::HALF_PI_Q13;
      e.clamped = 1'b1;
    end else begin
      s  = to_q30(sinp);
      s2 = (s < 0) ? -s : s;
      if (s2 > (64'd1 << QF)) s2 = 64'd1 << QF;
      c  = int_sqrt((64'd1 << (2 * QF)) - s2 * s2);
      e.pitch   = atan2_q13(s, longint'(c));
      e.clamped = 1'b0;
    end
    e.yaw  = atan2_q13(to_q30(siny), to_q30(cosy));
    e.roll = atan2_q13(to_q30(sinr), to_q30(cosr));
    angles_due.push_back(e);
  endfunction

  function void check_euler(q2e_pkg::q13_t yaw, q2e_pkg::q13_t pitch,
                            q2e_pkg::q13_t roll, logic clamped);
    euler_t e;
    if (angles_due.size() == 0) begin
      $display("%0t: unexpected result yaw %0d pitch %0d roll %0d clamped %0b",
               $time, yaw, pitch, roll, clamped);
      errors++;
      return;
    end
    e = angles_due.pop_front();
    if (yaw !== e.yaw) begin
      $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, yaw);
      errors++;
    end
    if (pitch !== e.pitch) begin
      $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, pitch);
      errors++;
    end
    if (roll !== e.roll) begin
      $display("%0t: roll expected %0d actual %0d", $time, e.roll, roll);
      errors++;
    end
    if (clamped !== e.clamped) begin
      $display("%0t: pitch_clamped expected %0b actual %0b", $time, e.clamped, clamped);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int NUM_RANDOM = 880;
  localparam int LATENCY    = 16 + 37;
  localparam int MAX_CYCLES = 200000;

  logic               clk;
  logic               rst;
  logic               quat_valid;
  logic               quat_ready;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  logic               euler_valid;
  logic               euler_ready;
  logic signed [15:0] yaw_angle, pitch_angle, roll_angle;
  logic               pitch_clamped;

  euler_scoreboard sb = new();
  bit              quiet;     // no idling on either side near the end
  int              cycles = 0;

  quaternion_to_euler_angles_core uut (
    .clk(clk), .rst(rst),
    .quat_valid(quat_valid), .quat_ready(quat_ready),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .euler_valid(euler_valid), .euler_ready(euler_ready),
    .yaw_angle(yaw_angle), .pitch_angle(pitch_angle), .roll_angle(roll_angle),
    .pitch_clamped(pitch_clamped)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Monitor: both handshakes are sampled at the edge, before driven updates land.
  always @(posedge clk) begin
    if (!rst && quat_valid && quat_ready)
      sb.note_quat(quat_w, quat_x, quat_y, quat_z);
    if (!rst && euler_valid && euler_ready)
      sb.check_euler(yaw_angle, pitch_angle, roll_angle, pitch_clamped);
  end

  // Result side: ready runs broken by random stall bursts until quiet is set.
  initial begin
    euler_ready = 1'b0;
    @(negedge rst);
    forever begin
      euler_ready <= 1'b1;
      repeat ($urandom_range(30, 1)) @(posedge clk);
      if (!quiet && $urandom_range(2) != 0) begin
        euler_ready <= 1'b0;
        repeat ($urandom_range(15, 1)) @(posedge clk);
      end
    end
  end

  // Present one item and hold it until accepted; optionally idle first.
  task automatic send_quat(input logic signed [15:0] w, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic signed [15:0] z);
    if (!quiet && $urandom_range(7) == 0) begin
      quat_valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
    quat_valid <= 1'b1;
    quat_w <= w;
    quat_x <= x;
    quat_y <= y;
    quat_z <= z;
    do @(posedge clk); while (!quat_ready);
  endtask

  function automatic logic signed [15:0] near(int centre, int spread);
    return 16'(centre + int'($urandom_range(2 * spread)) - spread);
  endfunction

  initial begin
    int pick, g;
    rst        = 1'b1;
    quat_valid = 1'b0;
    quat_w     = '0;
    quat_x     = '0;
    quat_y     = '0;
    quat_z     = '0;
    quiet      = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items.
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);              // all zero
    send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);          // identity
    send_quat(-16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);          // yaw atan2(0, negative) = +pi
    send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);          // roll = pi
    send_quat(16'sd0, 16'sd0, 16'sd8192, 16'sd8192);        // yaw atan2(0, 0)
    send_quat(16'sd16384, 16'sd0, 16'sd8192, 16'sd0);       // sin pitch exactly one
    send_quat(16'sd16384, 16'sd0, 16'sd8191, 16'sd0);       // just under one
    send_quat(16'sd16384, 16'sd0, -16'sd8192, 16'sd0);      // exactly minus one
    send_quat(16'sd16384, 16'sd0, -16'sd8191, 16'sd0);
    send_quat(16'sd11585, 16'sd0, 16'sd11585, 16'sd0);      // near gimbal lock, positive
    send_quat(16'sd11585, 16'sd0, -16'sd11585, 16'sd0);     // near gimbal lock, negative
    send_quat(16'sd11585, -16'sd11585, 16'sd0, 16'sd0);     // roll -pi/2
    send_quat(16'sd0, 16'sd0, -16'sd16384, 16'sd0);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
    send_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
    send_quat(16'sd0, -16'sd32768, 16'sd0, 16'sd32767);
    send_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1);
    send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);  // unit, 45 degree mix

    for (int n = 0; n < NUM_RANDOM; n++) begin
      // Hold off until the pipeline drains, once, mid-run.
      if (n == NUM_RANDOM / 2) begin
        quat_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      if (n == NUM_RANDOM - 120) quiet = 1'b1;
      pick = $urandom_range(99);
      if (pick < 50) begin
        // roughly unit-scale quaternions
        send_quat(near(0, 16384), near(0, 16384), near(0, 16384), near(0, 16384));
      end else if (pick < 70) begin
        // near gimbal lock: w ~ +-y, x ~ -+z
        g = $urandom_range(1) ? 11585 : -11585;
        send_quat(near(11585, 64), near(0, 300), near(g, 64), near(0, 300));
      end else begin
        // full range, every bit exercised
        send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end
    end
    quat_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+src
src/q2e_pkg.sv
src/q2e_front.sv
src/q2e_isqrt.sv
src/q2e_cordic.sv
src/quaternion_to_euler_angles_core.sv
test/tb.sv
